FILE: hw/rtl/spkpp_pkg.sv
// shared types and constants for the speaker pwm ping-pong player
// no dependencies; imported by every module of the block
package spkpp_pkg;

    localparam int BUFFER_SAMPLES = 4096;
    localparam int IDX_W          = $clog2(BUFFER_SAMPLES);
    localparam int HALF_SAMPLES   = BUFFER_SAMPLES / 2;

    localparam int SAMPLE_W  = 16;
    localparam int DIVISOR_W = 16;
    localparam int RELOAD_W  = 16;
    localparam int NEXT_W    = 12;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_TIMER_DIVISOR = '0;
    localparam logic [DIVISOR_W-1:0]  DIVISOR_RESET     = 16'd1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_WAIT  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_STARTED = 2'd1,
        ST_NOT_READY   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic                reload_valid;
        logic [RELOAD_W-1:0] reload_value;
        logic [NEXT_W-1:0]   next_index;
        logic                half_finished;
        logic                free_half;
    } t_out_item;

endpackage

FILE: hw/rtl/spkpp_regs.sv
// apb configuration register: timer divisor
// depends on spkpp_pkg
module spkpp_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spkpp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spkpp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spkpp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output logic [spkpp_pkg::DIVISOR_W-1:0]  o_divisor
);
    import spkpp_pkg::*;

    logic                 w_sel_div;
    logic                 w_wr;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [DIVISOR_W-1:0] n_divisor;

    assign pready    = 1'b1;
    assign w_sel_div = (paddr[CFG_ADDR_W-1:2] == REG_TIMER_DIVISOR);
    assign w_wr      = psel && penable && pwrite && w_sel_div;

    always_comb begin
        n_divisor = r_divisor;
        if (w_wr) begin
            n_divisor = pwdata[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DIVISOR_RESET;
        end else begin
            r_divisor <= n_divisor;
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        if (w_sel_div) begin
            prdata = CFG_DATA_W'(r_divisor);
        end
    end

    assign o_divisor = r_divisor;

endmodule

FILE: hw/rtl/spkpp_exec.sv
// player state and per-beat evaluation: reload math, index advance, half handoff
// depends on spkpp_pkg
module spkpp_exec (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  spkpp_pkg::t_in_item             i_item,
    input  logic [spkpp_pkg::DIVISOR_W-1:0] i_divisor,
    output spkpp_pkg::t_out_item            o_result
);
    import spkpp_pkg::*;

    logic             r_running;
    logic             r_active_half;
    logic             r_half_pending;
    logic [IDX_W-1:0] r_play_index;

    logic             n_running;
    logic             n_active_half;
    logic             n_half_pending;
    logic [IDX_W-1:0] n_play_index;

    logic [SAMPLE_W-1:0]           w_biased;
    logic [SAMPLE_W+DIVISOR_W-1:0] w_prod;
    logic [IDX_W:0]                w_inc;
    logic [16:0]                   w_idx_ext;

    // sample + 32768 is the sample with its sign bit flipped
    assign w_biased = {~i_item.sample[SAMPLE_W-1], i_item.sample[SAMPLE_W-2:0]};
    assign w_prod   = w_biased * i_divisor;
    assign w_inc    = {1'b0, r_play_index} + (IDX_W+1)'(1);

    always_comb begin
        n_running      = r_running;
        n_active_half  = r_active_half;
        n_half_pending = r_half_pending;
        n_play_index   = r_play_index;
        o_result       = '0;
        o_result.status = ST_OK;

        unique case (t_func'(i_item.func))
            FUNC_TICK: begin
                if (!r_running) begin
                    o_result.status = ST_NOT_STARTED;
                end else begin
                    o_result.reload_valid = 1'b1;
                    o_result.reload_value = w_prod[SAMPLE_W+DIVISOR_W-1 -: RELOAD_W];
                    n_play_index          = w_inc[IDX_W-1:0];
                    if (w_inc == (IDX_W+1)'(HALF_SAMPLES)) begin
                        n_half_pending         = 1'b1;
                        n_active_half          = ~r_active_half;
                        o_result.half_finished = 1'b1;
                    end else if (w_inc >= (IDX_W+1)'(BUFFER_SAMPLES)) begin
                        n_play_index           = '0;
                        n_half_pending         = 1'b1;
                        n_active_half          = ~r_active_half;
                        o_result.half_finished = 1'b1;
                    end
                end
            end
            FUNC_START: begin
                // first wait after start hands out half 1 at once
                n_running      = 1'b1;
                n_active_half  = 1'b0;
                n_half_pending = 1'b1;
                n_play_index   = '0;
            end
            FUNC_STOP: begin
                if (!r_running) begin
                    o_result.status = ST_NOT_STARTED;
                end else begin
                    n_running = 1'b0;
                end
            end
            FUNC_WAIT: begin
                if (!r_running) begin
                    o_result.status = ST_NOT_STARTED;
                end else if (r_half_pending) begin
                    o_result.free_half = ~r_active_half;
                    n_half_pending     = 1'b0;
                end else begin
                    o_result.status = ST_NOT_READY;
                end
            end
            default: begin
                o_result.status = ST_OK;
            end
        endcase

        w_idx_ext           = 17'(n_play_index);
        o_result.next_index = w_idx_ext[NEXT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_active_half  <= 1'b0;
            r_half_pending <= 1'b0;
            r_play_index   <= '0;
        end else if (i_fire) begin
            r_running      <= n_running;
            r_active_half  <= n_active_half;
            r_half_pending <= n_half_pending;
            r_play_index   <= n_play_index;
        end
    end

endmodule

FILE: hw/rtl/speaker_pwm_pingpong_player_core.sv
// top level of the speaker pwm ping-pong player
// depends on spkpp_pkg, spkpp_regs, spkpp_exec
//
// usage
// - input channel: i_in_valid / o_in_stall carry one command beat (func, sample);
//   a tick carries the sample at the index reported as next_index by the
//   previous tick (or 0 after start)
// - output channel: o_out_valid / i_out_stall carry exactly one result beat
//   per command beat, in order
// - apb port holds timer_divisor at byte address 0; write it only while idle
// - path: a beat taken lands in the input register, is evaluated and stored in
//   the result register once that is free, and is offered from then on
// - throughput: one beat per cycle while the receiver does not stall, set by a single
//   16x16 multiply and the index compare between the input and result registers
// - when the receiver stalls, the result register holds; the input register
//   keeps one more beat, and only then o_in_stall rises
// - reset (synchronous, active low): player stopped, index 0, no half pending,
//   divisor 1, both pipeline registers empty
module speaker_pwm_pingpong_player_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  spkpp_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output spkpp_pkg::t_out_item             o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spkpp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spkpp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spkpp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import spkpp_pkg::*;

    logic                 r_in_valid;
    t_in_item             r_in_item;
    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic                 n_in_valid;
    logic                 n_out_valid;

    logic                 w_fire;    // input register beat moves to result register
    logic                 w_take;    // new beat accepted from the input channel
    logic [DIVISOR_W-1:0] w_divisor;
    t_out_item            w_result;

    spkpp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_divisor (w_divisor)
    );

    spkpp_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in_item),
        .i_divisor (w_divisor),
        .o_result  (w_result)
    );

    // result register frees up when empty or drained this cycle
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_in_valid = 1'b0;
        end
        if (w_take) begin
            n_in_valid = 1'b1;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_fire) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: test/tb_speaker_pwm_pingpong_player_core.sv
// testbench for speaker_pwm_pingpong_player_core: command beats in, result beats checked
// against an in-bench prediction of the player; depends on spkpp_pkg and the core rtl
`timescale 1ns / 100ps

import spkpp_pkg::*;

// tracks the player state and the result beats still owed by the core
class player_model;
    logic [DIVISOR_W-1:0] divisor = DIVISOR_RESET;
    bit                   running;
    bit                   active_half;
    bit                   half_pending;
    int unsigned          play_index;
    t_out_item            owed[$];
    int unsigned          errors;

    function void set_divisor(logic [DIVISOR_W-1:0] d);
        divisor = d;
    endfunction

    function void note_failure(string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // predict the result beat of one accepted command
    function void take_command(t_in_item cmd);
        t_out_item            r;
        logic [SAMPLE_W-1:0]  biased;
        logic [31:0]          product;
        r = '0;
        r.status = ST_OK;
        case (cmd.func)
            FUNC_TICK: begin
                if (!running) begin
                    r.status = ST_NOT_STARTED;
                end else begin
                    // adding 32768 to a two's complement sample flips its sign bit
                    biased = cmd.sample ^ 16'h8000;
                    product = biased * divisor;
                    r.reload_valid = 1'b1;
                    r.reload_value = product[31:16];
                    play_index++;
                    if (play_index == HALF_SAMPLES) begin
                        half_pending = 1'b1;
                        active_half = !active_half;
                        r.half_finished = 1'b1;
                    end else if (play_index >= BUFFER_SAMPLES) begin
                        play_index = 0;
                        half_pending = 1'b1;
                        active_half = !active_half;
                        r.half_finished = 1'b1;
                    end
                end
            end
            FUNC_START: begin
                running = 1'b1;
                active_half = 1'b0;
                half_pending = 1'b1;
                play_index = 0;
            end
            FUNC_STOP: begin
                if (!running)
                    r.status = ST_NOT_STARTED;
                else
                    running = 1'b0;
            end
            default: begin
                if (!running) begin
                    r.status = ST_NOT_STARTED;
                end else if (half_pending) begin
                    r.free_half = !active_half;
                    half_pending = 1'b0;
                end else begin
                    r.status = ST_NOT_READY;
                end
            end
        endcase
        r.next_index = play_index[NEXT_W-1:0];
        owed.push_back(r);
    endfunction

    function string describe(t_out_item r);
        return $sformatf("status=%0d rv=%0d reload=%h idx=%0d hfin=%0d free=%0d",
                         r.status, r.reload_valid, r.reload_value, r.next_index,
                         r.half_finished, r.free_half);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        string     bad;
        if (owed.size() == 0) begin
            note_failure({"result beat with none owed: ", describe(got)});
            return;
        end
        want = owed.pop_front();
        bad = "";
        if (got.status !== want.status)               bad = {bad, " status"};
        if (got.reload_valid !== want.reload_valid)   bad = {bad, " reload_valid"};
        if (got.reload_value !== want.reload_value)   bad = {bad, " reload_value"};
        if (got.next_index !== want.next_index)       bad = {bad, " next_index"};
        if (got.half_finished !== want.half_finished) bad = {bad, " half_finished"};
        if (got.free_half !== want.free_half)         bad = {bad, " free_half"};
        if (bad != "")
            note_failure({"field(s)", bad, "; expected ", describe(want),
                          "; actual ", describe(got)});
    endfunction
endclass

module tb_speaker_pwm_pingpong_player_core;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    player_model model = new();

    // idle odds in percent, changed per phase
    int gap_pct   = 0;
    int stall_pct = 0;
    int beats_sent;

    speaker_pwm_pingpong_player_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stall, redrawn every cycle
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // every result beat taken at this edge is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            model.check_result(out_item);
    end

    // sample values lean toward the extremes of the signed range and toward 0 and -1
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // offer one command beat; valid stays high across back-to-back beats so that
    // it is never lowered and raised in the same step
    task automatic send_command(t_func f, logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{func: f, sample: s};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // beat taken at this edge; the payload is still the one driven
        model.take_command(in_item);
        beats_sent++;
    endtask

    // wait until every owed result beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (model.owed.size() != 0)
            @(posedge clk);
    endtask

    // apb write of the divisor, then a read back on the following transfer
    task automatic program_divisor(logic [DIVISOR_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TIMER_DIVISOR, 2'b00};
        pwdata  <= {16'h0000, d};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model.set_divisor(d);
        // straight into the setup cycle of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {16'h0000, d})
            model.note_failure($sformatf("divisor read back %h, wrote %h", prdata, d));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // a run of ticks with the odd wait query mixed in; may restart the player
    // first and may stop it at the end
    task automatic play_stretch(int ticks, bit restart);
        if (restart)
            send_command(FUNC_START, random_sample());
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(31) == 0)
                send_command(FUNC_WAIT, random_sample());
            send_command(FUNC_TICK, random_sample());
        end
        if ($urandom_range(2) == 0)
            send_command(FUNC_STOP, random_sample());
    endtask

    // mostly well-formed playback, some fully random commands as noise
    task automatic mixed_traffic(int quota);
        int stop_at;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at) begin
            if ($urandom_range(9) < 7)
                play_stretch($urandom_range(1, 80), $urandom_range(2) == 0);
            else
                repeat ($urandom_range(1, 5))
                    send_command(t_func'($urandom_range(3)), random_sample());
        end
    endtask

    logic [DIVISOR_W-1:0] divisor_plan [6];

    initial begin
        divisor_plan = '{16'hffff, 16'($urandom_range(1, 65535)), 16'h0000,
                         16'h0001, 16'($urandom_range(65535)), 16'h8000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every command while stopped, the start handshake, sample
        // extremes at the reset divisor, restart while running
        gap_pct   = 26;
        stall_pct = 80;
        send_command(FUNC_TICK,  16'h8000);   // tick while stopped
        send_command(FUNC_STOP,  16'h7fff);   // stop while stopped
        send_command(FUNC_WAIT,  16'hffff);   // wait while stopped
        send_command(FUNC_START, 16'h0000);
        send_command(FUNC_WAIT,  16'h0000);   // start leaves half 1 ready
        send_command(FUNC_WAIT,  16'h0000);   // nothing ready now
        send_command(FUNC_TICK,  16'h8000);
        send_command(FUNC_TICK,  16'h7fff);
        send_command(FUNC_TICK,  16'h0000);
        send_command(FUNC_TICK,  16'hffff);
        send_command(FUNC_STOP,  16'h1234);   // stop while running
        send_command(FUNC_TICK,  16'h7fff);
        send_command(FUNC_WAIT,  16'h0001);
        send_command(FUNC_STOP,  16'h0000);
        send_command(FUNC_START, 16'h5555);
        send_command(FUNC_TICK,  16'h0001);
        send_command(FUNC_TICK,  16'haaaa);
        send_command(FUNC_START, 16'h0000);   // restart while running
        send_command(FUNC_TICK,  16'h7fff);
        send_command(FUNC_WAIT,  16'h0000);
        send_command(FUNC_WAIT,  16'h0000);
        send_command(FUNC_STOP,  16'h0000);

        // three idle profiles, two divisor settings each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin gap_pct = 26; stall_pct = 80; end
                1:       begin gap_pct = 80; stall_pct = 26; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            for (int k = 0; k < 2; k++) begin
                drain();
                program_divisor(divisor_plan[2 * ph + k]);
                mixed_traffic(150);
            end
        end

        // a short closing playback from a fresh start, nothing idling
        play_stretch(48, 1'b1);

        drain();
        repeat (4) @(posedge clk);
        if (model.errors == 0 && model.owed.size() == 0)
            $display("speaker_pwm_pingpong_player_core test passed");
        else
            $display("speaker_pwm_pingpong_player_core test failed");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #1000000;
        $display("speaker_pwm_pingpong_player_core test failed");
        $finish;
    end

endmodule
